>>> hw/rtl/cfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

   // Payload buffer depth; indexes at or above it are reported as not kept.
   localparam int unsigned CFP_PAYLOAD_DEPTH = 1024;

   localparam int unsigned CFP_CSR_INDEX_W = 2;
   localparam int unsigned CFP_CSR_DATA_W  = 8;

   // Register indexes of the configuration port.
   localparam logic [CFP_CSR_INDEX_W-1:0] CFP_CSR_MARKER    = 2'd0;
   localparam logic [CFP_CSR_INDEX_W-1:0] CFP_CSR_LONG_LOAD = 2'd1;
   localparam logic [CFP_CSR_INDEX_W-1:0] CFP_CSR_START     = 2'd2;
   localparam logic [CFP_CSR_INDEX_W-1:0] CFP_CSR_STOP      = 2'd3;

   typedef struct packed {
      logic [7:0] rx_byte;
   } cfp_req_type;

   typedef struct packed {
      logic [7:0]  frame_command;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic        has_payload_byte;
      logic        byte_kept;
      logic        frame_done;
      logic [15:0] frame_length;
      logic        streaming_on;
   } cfp_rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/cfp_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cfp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/command_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Command frame parser. Received bytes enter on req_chan, one item per byte;
// the parser looks for frames of the form marker, command, length (one byte,
// or two bytes high byte first for the long-load command), payload. Each
// payload byte leaves on rsp_chan with its index, a kept flag (index below
// the payload buffer depth) and frame_done on the last byte; a zero-length
// short frame gives a single item with no payload byte. Marker, command and
// length bytes give no item, and an empty long-load frame vanishes silently.
// Start and stop frames set or clear streaming_on when they complete.
// Throughput is one byte per clock while the output is not stalled: a byte is
// registered on entry, parsed by one level of compare and increment logic, and
// its result lands in the output register. The input register is free whenever
// the output register is empty or being drained.
// Configuration registers are written through the csr_ port; the user must write
// them only while the parser holds no byte, as the parser does not enforce this.
module command_frame_parser #(
   parameter int unsigned PAYLOAD_DEPTH = cfp_pkg::CFP_PAYLOAD_DEPTH
) (
   input  wire                                     clock,
   input  wire                                     reset,
   cfp_stream_if.sink                              req_chan,
   cfp_stream_if.source                            rsp_chan,
   input  wire                                     csr_write_en,
   input  wire [cfp_pkg::CFP_CSR_INDEX_W-1:0]      csr_index,
   input  wire [cfp_pkg::CFP_CSR_DATA_W-1:0]       csr_wdata
);

   // Parse phases.
   localparam logic [2:0] PH_MARKER  = 3'd0;
   localparam logic [2:0] PH_CMD     = 3'd1;
   localparam logic [2:0] PH_LEN     = 3'd2;
   localparam logic [2:0] PH_LEN2    = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   localparam logic [16:0] DEPTH_LIMIT = 17'(PAYLOAD_DEPTH);

   // Configuration registers.
   logic [7:0] marker_ff, long_load_ff, start_cmd_ff, stop_cmd_ff;

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // Parser state.
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  len_high_ff, len_high_in;
   logic [15:0] exp_len_ff, exp_len_in;
   logic [15:0] count_ff, count_in;
   logic        stream_ff, stream_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   cfp_pkg::cfp_rsp_type rsp_ff, rsp_in;

   logic        consume;
   logic [15:0] count_next;
   logic        payload_done;
   logic        cmd_stream;

   // Advance the held byte whenever the output register can take a result.
   assign consume        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || consume;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   assign count_next   = count_ff + 16'd1;
   assign payload_done = count_next >= exp_len_ff;

   // Streaming flag after a frame of the held command completes; start wins.
   always_comb begin
      if (command_ff == start_cmd_ff) begin
         cmd_stream = 1'b1;
      end else if (command_ff == stop_cmd_ff) begin
         cmd_stream = 1'b0;
      end else begin
         cmd_stream = stream_ff;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      command_in   = command_ff;
      len_high_in  = len_high_ff;
      exp_len_in   = exp_len_ff;
      count_in     = count_ff;
      stream_in    = stream_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      if (consume) begin
         rsp_in.frame_command    = command_ff;
         rsp_in.data_byte        = 8'd0;
         rsp_in.byte_index       = 16'd0;
         rsp_in.has_payload_byte = 1'b0;
         rsp_in.byte_kept        = 1'b0;
         rsp_in.frame_done       = 1'b0;
         rsp_in.frame_length     = exp_len_ff;
         rsp_in.streaming_on     = stream_ff;
         rsp_valid_in            = 1'b0;

         case (phase_ff)
            PH_CMD: begin
               command_in = in_byte_ff;
               phase_in   = PH_LEN;
            end
            PH_LEN: begin
               if (command_ff == long_load_ff) begin
                  len_high_in = in_byte_ff;
                  phase_in    = PH_LEN2;
               end else begin
                  count_in   = 16'd0;
                  exp_len_in = {8'd0, in_byte_ff};
                  if (in_byte_ff == 8'd0) begin
                     // Zero-length short frame: report it and apply the command.
                     stream_in                = cmd_stream;
                     phase_in                 = PH_MARKER;
                     rsp_in.frame_done        = 1'b1;
                     rsp_in.frame_length      = 16'd0;
                     rsp_in.streaming_on      = cmd_stream;
                     rsp_valid_in             = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_LEN2: begin
               // Drop an empty long-load frame without a result.
               exp_len_in = {len_high_ff, in_byte_ff};
               count_in   = 16'd0;
               phase_in   = ({len_high_ff, in_byte_ff} == 16'd0) ? PH_MARKER : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               count_in                = count_next;
               rsp_in.data_byte        = in_byte_ff;
               rsp_in.byte_index       = count_ff;
               rsp_in.has_payload_byte = 1'b1;
               rsp_in.byte_kept        = {1'b0, count_ff} < DEPTH_LIMIT;
               rsp_in.frame_done       = payload_done;
               rsp_valid_in            = 1'b1;
               if (payload_done) begin
                  stream_in           = cmd_stream;
                  phase_in            = PH_MARKER;
                  rsp_in.streaming_on = cmd_stream;
               end
            end
            default: begin
               phase_in = (in_byte_ff == marker_ff) ? PH_CMD : PH_MARKER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff    <= 8'd0;
         long_load_ff <= 8'd0;
         start_cmd_ff <= 8'd0;
         stop_cmd_ff  <= 8'd0;
      end else if (csr_write_en) begin
         case (csr_index)
            cfp_pkg::CFP_CSR_MARKER:    marker_ff    <= csr_wdata;
            cfp_pkg::CFP_CSR_LONG_LOAD: long_load_ff <= csr_wdata;
            cfp_pkg::CFP_CSR_START:     start_cmd_ff <= csr_wdata;
            cfp_pkg::CFP_CSR_STOP:      stop_cmd_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_MARKER;
         command_ff   <= 8'd0;
         len_high_ff  <= 8'd0;
         exp_len_ff   <= 16'd0;
         count_ff     <= 16'd0;
         stream_ff    <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         command_ff   <= command_in;
         len_high_ff  <= len_high_in;
         exp_len_ff   <= exp_len_in;
         count_ff     <= count_in;
         stream_ff    <= stream_in;
      end
   end

   // Payload registers: hold the byte until it is parsed, hold the result until taken.
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.data.rx_byte;
      end
      rsp_ff <= rsp_in;
   end

   // A result without a payload byte only ever closes a zero-length frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.has_payload_byte |-> rsp_ff.frame_done)
      else $error("payload-less result that does not end a frame");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.byte_kept |-> rsp_ff.has_payload_byte)
      else $error("kept flag without a payload byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_done && rsp_ff.has_payload_byte
      |-> ({1'b0, rsp_ff.byte_index} + 17'd1) == {1'b0, rsp_ff.frame_length})
      else $error("frame closed before its last payload byte");

   assert property (@(posedge clock) disable iff (reset)
      consume && phase_ff == PH_PAYLOAD && payload_done |=> phase_ff == PH_MARKER)
      else $error("parser did not return to marker search after a frame");

endmodule

`default_nettype wire
